// File: rtl/lpgbe_pkg.sv
package lpgbe_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 1024;

  // configuration register indexes
  localparam logic [2:0] CFG_RED_GAIN     = 3'd0;
  localparam logic [2:0] CFG_GREEN_GAIN   = 3'd1;
  localparam logic [2:0] CFG_BLUE_GAIN    = 3'd2;
  localparam logic [2:0] CFG_STRIP_LENGTH = 3'd3;
  localparam logic [2:0] CFG_COLOUR_ORDER = 3'd4;
  localparam logic [2:0] CFG_CHIP_VARIANT = 3'd5;

  localparam logic [17:0] GAIN_UNITY      = 18'h10000;
  localparam logic [10:0] STRIP_LEN_RST   = 11'd1024;
  localparam logic [11:0] COLOUR_ORD_RST  = 12'h012;

  localparam logic [7:0] HDR_BASE = 8'hE0;
  localparam logic [7:0] HDR_FULL = 8'hFF;

  // per-stage advance strobes of the pipeline
  typedef struct packed {
    logic en_b;
    logic en_c;
    logic en_d;
    logic en_e;
  } lpgbe_adv_t;

  localparam int unsigned INV_PWM_NUM = 31 * 256;
  localparam int unsigned INV_RED_NUM = 31 * 240;
  localparam int unsigned INV_GB_NUM  = 31 * 128;
  localparam int unsigned INV_RED_OFS = 256 - 240;
  localparam int unsigned INV_GB_OFS  = 256 - 128;

  localparam logic [12:0] INV_PWM [32] = '{
    13'd0,
    13'(INV_PWM_NUM / 1),  13'(INV_PWM_NUM / 2),  13'(INV_PWM_NUM / 3),
    13'(INV_PWM_NUM / 4),  13'(INV_PWM_NUM / 5),  13'(INV_PWM_NUM / 6),
    13'(INV_PWM_NUM / 7),  13'(INV_PWM_NUM / 8),  13'(INV_PWM_NUM / 9),
    13'(INV_PWM_NUM / 10), 13'(INV_PWM_NUM / 11), 13'(INV_PWM_NUM / 12),
    13'(INV_PWM_NUM / 13), 13'(INV_PWM_NUM / 14), 13'(INV_PWM_NUM / 15),
    13'(INV_PWM_NUM / 16), 13'(INV_PWM_NUM / 17), 13'(INV_PWM_NUM / 18),
    13'(INV_PWM_NUM / 19), 13'(INV_PWM_NUM / 20), 13'(INV_PWM_NUM / 21),
    13'(INV_PWM_NUM / 22), 13'(INV_PWM_NUM / 23), 13'(INV_PWM_NUM / 24),
    13'(INV_PWM_NUM / 25), 13'(INV_PWM_NUM / 26), 13'(INV_PWM_NUM / 27),
    13'(INV_PWM_NUM / 28), 13'(INV_PWM_NUM / 29), 13'(INV_PWM_NUM / 30),
    13'(INV_PWM_NUM / 31)
  };

  localparam logic [12:0] INV_RED [32] = '{
    13'd0,
    13'(INV_RED_NUM / 1 + INV_RED_OFS),  13'(INV_RED_NUM / 2 + INV_RED_OFS),
    13'(INV_RED_NUM / 3 + INV_RED_OFS),  13'(INV_RED_NUM / 4 + INV_RED_OFS),
    13'(INV_RED_NUM / 5 + INV_RED_OFS),  13'(INV_RED_NUM / 6 + INV_RED_OFS),
    13'(INV_RED_NUM / 7 + INV_RED_OFS),  13'(INV_RED_NUM / 8 + INV_RED_OFS),
    13'(INV_RED_NUM / 9 + INV_RED_OFS),  13'(INV_RED_NUM / 10 + INV_RED_OFS),
    13'(INV_RED_NUM / 11 + INV_RED_OFS), 13'(INV_RED_NUM / 12 + INV_RED_OFS),
    13'(INV_RED_NUM / 13 + INV_RED_OFS), 13'(INV_RED_NUM / 14 + INV_RED_OFS),
    13'(INV_RED_NUM / 15 + INV_RED_OFS), 13'(INV_RED_NUM / 16 + INV_RED_OFS),
    13'(INV_RED_NUM / 17 + INV_RED_OFS), 13'(INV_RED_NUM / 18 + INV_RED_OFS),
    13'(INV_RED_NUM / 19 + INV_RED_OFS), 13'(INV_RED_NUM / 20 + INV_RED_OFS),
    13'(INV_RED_NUM / 21 + INV_RED_OFS), 13'(INV_RED_NUM / 22 + INV_RED_OFS),
    13'(INV_RED_NUM / 23 + INV_RED_OFS), 13'(INV_RED_NUM / 24 + INV_RED_OFS),
    13'(INV_RED_NUM / 25 + INV_RED_OFS), 13'(INV_RED_NUM / 26 + INV_RED_OFS),
    13'(INV_RED_NUM / 27 + INV_RED_OFS), 13'(INV_RED_NUM / 28 + INV_RED_OFS),
    13'(INV_RED_NUM / 29 + INV_RED_OFS), 13'(INV_RED_NUM / 30 + INV_RED_OFS),
    13'(INV_RED_NUM / 31 + INV_RED_OFS)
  };

  localparam logic [12:0] INV_GB [32] = '{
    13'd0,
    13'(INV_GB_NUM / 1 + INV_GB_OFS),  13'(INV_GB_NUM / 2 + INV_GB_OFS),
    13'(INV_GB_NUM / 3 + INV_GB_OFS),  13'(INV_GB_NUM / 4 + INV_GB_OFS),
    13'(INV_GB_NUM / 5 + INV_GB_OFS),  13'(INV_GB_NUM / 6 + INV_GB_OFS),
    13'(INV_GB_NUM / 7 + INV_GB_OFS),  13'(INV_GB_NUM / 8 + INV_GB_OFS),
    13'(INV_GB_NUM / 9 + INV_GB_OFS),  13'(INV_GB_NUM / 10 + INV_GB_OFS),
    13'(INV_GB_NUM / 11 + INV_GB_OFS), 13'(INV_GB_NUM / 12 + INV_GB_OFS),
    13'(INV_GB_NUM / 13 + INV_GB_OFS), 13'(INV_GB_NUM / 14 + INV_GB_OFS),
    13'(INV_GB_NUM / 15 + INV_GB_OFS), 13'(INV_GB_NUM / 16 + INV_GB_OFS),
    13'(INV_GB_NUM / 17 + INV_GB_OFS), 13'(INV_GB_NUM / 18 + INV_GB_OFS),
    13'(INV_GB_NUM / 19 + INV_GB_OFS), 13'(INV_GB_NUM / 20 + INV_GB_OFS),
    13'(INV_GB_NUM / 21 + INV_GB_OFS), 13'(INV_GB_NUM / 22 + INV_GB_OFS),
    13'(INV_GB_NUM / 23 + INV_GB_OFS), 13'(INV_GB_NUM / 24 + INV_GB_OFS),
    13'(INV_GB_NUM / 25 + INV_GB_OFS), 13'(INV_GB_NUM / 26 + INV_GB_OFS),
    13'(INV_GB_NUM / 27 + INV_GB_OFS), 13'(INV_GB_NUM / 28 + INV_GB_OFS),
    13'(INV_GB_NUM / 29 + INV_GB_OFS), 13'(INV_GB_NUM / 30 + INV_GB_OFS),
    13'(INV_GB_NUM / 31 + INV_GB_OFS)
  };

  // ceil(2^RECIP_SH / level): exact floor division for dividends below 2^21
  localparam int unsigned RECIP_SH  = 26;
  localparam int unsigned RECIP_ONE = 1 << RECIP_SH;

  localparam logic [26:0] RECIP [32] = '{
    27'd0,
    27'((RECIP_ONE + 0) / 1),   27'((RECIP_ONE + 1) / 2),   27'((RECIP_ONE + 2) / 3),
    27'((RECIP_ONE + 3) / 4),   27'((RECIP_ONE + 4) / 5),   27'((RECIP_ONE + 5) / 6),
    27'((RECIP_ONE + 6) / 7),   27'((RECIP_ONE + 7) / 8),   27'((RECIP_ONE + 8) / 9),
    27'((RECIP_ONE + 9) / 10),  27'((RECIP_ONE + 10) / 11), 27'((RECIP_ONE + 11) / 12),
    27'((RECIP_ONE + 12) / 13), 27'((RECIP_ONE + 13) / 14), 27'((RECIP_ONE + 14) / 15),
    27'((RECIP_ONE + 15) / 16), 27'((RECIP_ONE + 16) / 17), 27'((RECIP_ONE + 17) / 18),
    27'((RECIP_ONE + 18) / 19), 27'((RECIP_ONE + 19) / 20), 27'((RECIP_ONE + 20) / 21),
    27'((RECIP_ONE + 21) / 22), 27'((RECIP_ONE + 22) / 23), 27'((RECIP_ONE + 23) / 24),
    27'((RECIP_ONE + 24) / 25), 27'((RECIP_ONE + 25) / 26), 27'((RECIP_ONE + 26) / 27),
    27'((RECIP_ONE + 27) / 28), 27'((RECIP_ONE + 28) / 29), 27'((RECIP_ONE + 29) / 30),
    27'((RECIP_ONE + 30) / 31)
  };

  function automatic logic [4:0] clamp_level(logic [5:0] raw);
    logic [4:0] lvl;
    if (raw[5]) begin
      lvl = 5'd31;
    end else if (raw == 6'd0) begin
      lvl = 5'd1;
    end else begin
      lvl = raw[4:0];
    end
    return lvl;
  endfunction

  function automatic logic [12:0] inv_factor(logic variant, logic is_red, logic [4:0] level);
    logic [12:0] f;
    if (!variant) begin
      f = INV_PWM[level];
    end else if (is_red) begin
      f = INV_RED[level];
    end else begin
      f = INV_GB[level];
    end
    return f;
  endfunction

endpackage

// File: rtl/lpgbe_scale16.sv
module lpgbe_scale16 (
  input  logic                     clk_i,
  input  lpgbe_pkg::lpgbe_adv_t    adv_i,
  input  logic [2:0][15:0]         colour_i,
  input  logic [2:0][17:0]         gain_i,
  input  logic                     chip_variant_i,
  output logic [7:0]               header_o,
  output logic [2:0][7:0]          byte_o
);
  import lpgbe_pkg::*;

  logic [2:0][33:0] prod_b;
  logic [2:0][15:0] scaled_d, scaled_q;
  logic [2:0][15:0] scaled_c_q;
  logic [15:0]      mx_c;
  logic [16:0]      sum_c;
  logic [4:0]       lvl_d, lvl_q;
  logic [2:0][28:0] prod_d;
  logic [2:0][7:0]  byte_d, byte_q;
  logic [7:0]       header_d, header_q;
  logic [12:0]      fac;

  // stage B: gain multiply, saturate to 16 bits
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_b[k]   = colour_i[k] * gain_i[k];
      scaled_d[k] = (|prod_b[k][33:32]) ? 16'hFFFF : prod_b[k][31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_b) begin
      scaled_q <= scaled_d;
    end
  end

  // stage C: level from the largest scaled component
  always_comb begin
    mx_c = scaled_q[0];
    if (scaled_q[1] > mx_c) mx_c = scaled_q[1];
    if (scaled_q[2] > mx_c) mx_c = scaled_q[2];
    sum_c = {1'b0, mx_c} + 17'h00400;
    lvl_d = clamp_level(sum_c[16:11]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_c) begin
      scaled_c_q <= scaled_q;
      lvl_q      <= lvl_d;
    end
  end

  // stage D: compensate through the inverse table
  always_comb begin
    fac = '0;
    for (int k = 0; k < 3; k++) begin
      fac       = inv_factor(chip_variant_i, k == 0, lvl_q);
      prod_d[k] = scaled_c_q[k] * fac;
      byte_d[k] = (|prod_d[k][28:24]) ? 8'hFF : prod_d[k][23:16];
    end
    header_d = HDR_BASE | {3'b000, lvl_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_d) begin
      byte_q   <= byte_d;
      header_q <= header_d;
    end
  end

  assign byte_o   = byte_q;
  assign header_o = header_q;

endmodule

// File: rtl/lpgbe_comp8.sv
module lpgbe_comp8 (
  input  logic                     clk_i,
  input  lpgbe_pkg::lpgbe_adv_t    adv_i,
  input  logic [2:0][17:0]         gain_i,
  input  logic                     chip_variant_i,
  output logic [7:0]               header_o,
  output logic [2:0][20:0]         comp_o
);
  import lpgbe_pkg::*;

  logic [17:0]      mx_b;
  logic [16:0]      sum_b;
  logic             under_b;
  logic [4:0]       lvl_b;
  logic [2:0][20:0] dvd_b;

  logic [2:0][20:0] dvd_q;
  logic [26:0]      recip_q;
  logic [4:0]       lvl_b_q;
  logic             under_b_q;

  logic [2:0][34:0] pp_lo_d, pp_lo_q;
  logic [2:0][33:0] pp_hi_d, pp_hi_q;
  logic [2:0][28:0] cur_prod;
  logic [2:0][20:0] comp_cur_d, comp_cur_q;
  logic [12:0]      fac;
  logic [4:0]       lvl_c_q;
  logic             under_c_q;

  logic [2:0][47:0] full_d;
  logic [2:0][20:0] comp_d, comp_q;
  logic [7:0]       header_d, header_q;

  // stage B: level from the largest gain, dividend gain * 31
  always_comb begin
    mx_b = gain_i[0];
    if (gain_i[1] > mx_b) mx_b = gain_i[1];
    if (gain_i[2] > mx_b) mx_b = gain_i[2];
    under_b = ~(|mx_b[17:16]);
    sum_b   = {1'b0, mx_b[15:0]} + 17'h003FF;
    lvl_b   = clamp_level(sum_b[16:11]);
    for (int k = 0; k < 3; k++) begin
      dvd_b[k] = {gain_i[k][15:0], 5'b00000} - {5'b00000, gain_i[k][15:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_b) begin
      dvd_q     <= dvd_b;
      recip_q   <= RECIP[lvl_b];
      lvl_b_q   <= lvl_b;
      under_b_q <= under_b;
    end
  end

  // stage C: reciprocal multiply in two partial products; current-driver factor
  always_comb begin
    fac = '0;
    for (int k = 0; k < 3; k++) begin
      pp_lo_d[k]    = dvd_q[k] * recip_q[13:0];
      pp_hi_d[k]    = dvd_q[k] * recip_q[26:14];
      fac           = inv_factor(1'b1, k == 0, lvl_b_q);
      cur_prod[k]   = gain_i[k][15:0] * fac;
      comp_cur_d[k] = cur_prod[k][28:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_c) begin
      pp_lo_q    <= pp_lo_d;
      pp_hi_q    <= pp_hi_d;
      comp_cur_q <= comp_cur_d;
      lvl_c_q    <= lvl_b_q;
      under_c_q  <= under_b_q;
    end
  end

  // stage D: combine partial products, pick the factor
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      full_d[k] = ({14'd0, pp_hi_q[k]} << 14) + {13'd0, pp_lo_q[k]};
      if (!under_c_q) begin
        comp_d[k] = {3'b000, gain_i[k]};
      end else if (chip_variant_i) begin
        comp_d[k] = comp_cur_q[k];
      end else begin
        comp_d[k] = full_d[k][46:26];
      end
    end
    header_d = under_c_q ? (HDR_BASE | {3'b000, lvl_c_q}) : HDR_FULL;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_d) begin
      comp_q   <= comp_d;
      header_q <= header_d;
    end
  end

  assign comp_o   = comp_q;
  assign header_o = header_q;

endmodule

// File: rtl/lpgbe_slot_pack.sv
module lpgbe_slot_pack (
  input  logic                     clk_i,
  input  lpgbe_pkg::lpgbe_adv_t    adv_i,
  input  logic                     cmd_i,
  input  logic [2:0][7:0]          v8_i,
  input  logic [2:0][7:0]          byte16_i,
  input  logic [7:0]               header16_i,
  input  logic [2:0][20:0]         comp_i,
  input  logic [7:0]               header8_i,
  input  logic [11:0]              colour_order_i,
  output logic [7:0]               header_o,
  output logic [2:0][7:0]          slot_o
);
  import lpgbe_pkg::*;

  logic [2:0][28:0] prod;
  logic [2:0][7:0]  colour_byte;
  logic [3:0]       pos;
  logic [2:0][7:0]  slot_d, slot_q;
  logic [7:0]       header_d, header_q;

  // stage E: eight-bit scaling when cmd_i is set (else the sixteen-bit bytes), then place colours by the order nibbles
  always_comb begin
    slot_d = '0;
    pos    = '0;
    for (int k = 0; k < 3; k++) begin
      prod[k] = v8_i[k] * comp_i[k];
      if (cmd_i) begin
        colour_byte[k] = (|prod[k][28:24]) ? 8'hFF : prod[k][23:16];
      end else begin
        colour_byte[k] = byte16_i[k];
      end
    end
    // later colour wins a shared slot; positions above two are dropped
    for (int k = 0; k < 3; k++) begin
      pos = colour_order_i[(8 - 4 * k) +: 4];
      if (pos <= 4'd2) begin
        slot_d[2'(2'd2 - pos[1:0])] = colour_byte[k];
      end
    end
    header_d = cmd_i ? header8_i : header16_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en_e) begin
      slot_q   <= slot_d;
      header_q <= header_d;
    end
  end

  assign slot_o   = slot_q;
  assign header_o = header_q;

endmodule

// File: rtl/led_pixel_global_brightness_encoder.sv
// Throughput: one pixel per cycle unless m_axis_tready stalls the output; five register
// stages (input, gain multiply, level choice and reciprocal products, compensation
// multiply, output) move together. Pixels at or beyond the strip length or MAX_PIXELS
// are dropped at the input. Reset (rst_ni low, asynchronous) empties the pipeline and
// returns the registers to unity gains, 1024 pixels, colour order 0x012 and the PWM
// variant.
module led_pixel_global_brightness_encoder #(
  parameter int unsigned MAX_PIXELS = lpgbe_pkg::MAX_PIXELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_number[15:0], red_in[31:16], green_in[47:32], blue_in[63:48]
  input  logic [63:0] s_axis_tdata,
  // command[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_offset[12:0], header_byte[20:13], slot_byte_one[28:21],
  // slot_byte_two[36:29], slot_byte_three[44:37], zero[47:45]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);
  import lpgbe_pkg::*;

  logic [17:0] red_gain_q, green_gain_q, blue_gain_q;
  logic [10:0] strip_len_q;
  logic [11:0] colour_ord_q;
  logic        variant_q;

  logic [2:0][17:0] gain;

  logic [15:0] idx;
  logic        keep;

  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  lpgbe_adv_t adv;

  logic             cmd_a_q, cmd_b_q, cmd_c_q, cmd_d_q;
  logic [12:0]      off_a_q, off_b_q, off_c_q, off_d_q, off_e_q;
  logic [2:0][15:0] col_a_q;
  logic [2:0][7:0]  v8_b_q, v8_c_q, v8_d_q;

  logic [7:0]       header16, header8, header_e;
  logic [2:0][7:0]  byte16;
  logic [2:0][20:0] comp8;
  logic [2:0][7:0]  slot_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_q   <= GAIN_UNITY;
      green_gain_q <= GAIN_UNITY;
      blue_gain_q  <= GAIN_UNITY;
      strip_len_q  <= STRIP_LEN_RST;
      colour_ord_q <= COLOUR_ORD_RST;
      variant_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RED_GAIN:     red_gain_q   <= cfg_data_i;
        CFG_GREEN_GAIN:   green_gain_q <= cfg_data_i;
        CFG_BLUE_GAIN:    blue_gain_q  <= cfg_data_i;
        CFG_STRIP_LENGTH: strip_len_q  <= cfg_data_i[10:0];
        CFG_COLOUR_ORDER: colour_ord_q <= cfg_data_i[11:0];
        CFG_CHIP_VARIANT: variant_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign gain = {blue_gain_q, green_gain_q, red_gain_q};

  // a stage takes a beat when empty or when its successor takes one
  assign rdy_e = ~vld_e_q | m_axis_tready;
  assign rdy_d = ~vld_d_q | rdy_e;
  assign rdy_c = ~vld_c_q | rdy_d;
  assign rdy_b = ~vld_b_q | rdy_c;
  assign rdy_a = ~vld_a_q | rdy_b;

  assign adv.en_b = rdy_b;
  assign adv.en_c = rdy_c;
  assign adv.en_d = rdy_d;
  assign adv.en_e = rdy_e;

  assign s_axis_tready = rdy_a;

  assign idx  = s_axis_tdata[15:0];
  assign keep = ({1'b0, idx} < 17'(MAX_PIXELS)) && (idx < {5'b00000, strip_len_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= s_axis_tvalid & keep;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
      if (rdy_d) vld_d_q <= vld_c_q;
      if (rdy_e) vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      cmd_a_q    <= s_axis_tuser[0];
      off_a_q    <= {idx[10:0] + 11'd1, 2'b00};
      col_a_q[0] <= s_axis_tdata[31:16];
      col_a_q[1] <= s_axis_tdata[47:32];
      col_a_q[2] <= s_axis_tdata[63:48];
    end
    if (rdy_b) begin
      cmd_b_q <= cmd_a_q;
      off_b_q <= off_a_q;
      for (int k = 0; k < 3; k++) begin
        v8_b_q[k] <= col_a_q[k][7:0];
      end
    end
    if (rdy_c) begin
      cmd_c_q <= cmd_b_q;
      off_c_q <= off_b_q;
      v8_c_q  <= v8_b_q;
    end
    if (rdy_d) begin
      cmd_d_q <= cmd_c_q;
      off_d_q <= off_c_q;
      v8_d_q  <= v8_c_q;
    end
    if (rdy_e) begin
      off_e_q <= off_d_q;
    end
  end

  lpgbe_scale16 u_scale16 (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .colour_i       (col_a_q),
    .gain_i         (gain),
    .chip_variant_i (variant_q),
    .header_o       (header16),
    .byte_o         (byte16)
  );

  lpgbe_comp8 u_comp8 (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .gain_i         (gain),
    .chip_variant_i (variant_q),
    .header_o       (header8),
    .comp_o         (comp8)
  );

  lpgbe_slot_pack u_slot_pack (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .cmd_i          (cmd_d_q),
    .v8_i           (v8_d_q),
    .byte16_i       (byte16),
    .header16_i     (header16),
    .comp_i         (comp8),
    .header8_i      (header8),
    .colour_order_i (colour_ord_q),
    .header_o       (header_e),
    .slot_o         (slot_e)
  );

  assign m_axis_tvalid = vld_e_q;
  assign m_axis_tdata  = {3'b000, slot_e[2], slot_e[1], slot_e[0], header_e, off_e_q};

endmodule
